FILE: rtl/s2t_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2t_pkg: shared types and constants for seconds_to_dhms_text
// Phase codes, divisors and their reciprocals, character codes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package s2t_pkg;

  localparam int SecWidth   = 32;
  localparam int CharWidth  = 6;
  localparam int CodeWidth  = 4;
  localparam int MaxChars   = 14;
  localparam int DaysBcdW   = 20;
  localparam int FieldBcdW  = 8;
  localparam int DaysBinW   = 16;
  localparam int FieldBinW  = 6;
  localparam int DaysDigits = 5;
  localparam int StrWidth   = MaxChars * CodeWidth;

  // Split phases, in the order they run
  localparam logic [1:0] PH_DAYS  = 2'd0;
  localparam logic [1:0] PH_HOURS = 2'd1;
  localparam logic [1:0] PH_MINS  = 2'd2;

  // Character codes held in the text shift register
  localparam logic [CodeWidth-1:0] CODE_SPACE = 4'd10;
  localparam logic [CodeWidth-1:0] CODE_COLON = 4'd11;

  localparam logic [CharWidth-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CharWidth-1:0] ASCII_SPACE = 6'd32;
  localparam logic [CharWidth-1:0] ASCII_COLON = 6'd58;

  localparam logic [SecWidth-1:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [SecWidth-1:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [SecWidth-1:0] SECS_PER_MIN  = 32'd60;

  // Reciprocals, rounded up. x / 86400 = (x >> 7) / 675, x / 3600 =
  // (x >> 4) / 225 and x / 60 = (x >> 2) / 15; each multiply-shift is exact
  // over the whole range its operand can take.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675
  localparam logic [13:0] RECIP_HOUR = 14'd9321;      // 2^21 / 225
  localparam logic [10:0] RECIP_MIN  = 11'd1093;      // 2^14 / 15
  localparam logic [15:0] RECIP_TEN  = 16'd52429;     // 2^19 / 10

  typedef struct packed {
    logic       load;    // capture a new count
    logic       quot;    // capture the quotient of the current phase
    logic       reduce;  // subtract quotient times divisor, store the field
    logic       digit;   // peel one decimal digit of days
    logic [1:0] phase;   // phase of the current split step
    logic       pack;    // assemble the text from the fields
    logic       shift;   // advance to the next character
  } ctl_cmd_t;

  typedef struct packed {
    logic [3:0] len;    // character count of the assembled text
  } ctl_sts_t;

  // Two BCD digits of a value below 64: tens by multiply-shift, then ones
  function automatic logic [FieldBcdW-1:0] bcd2(input logic [FieldBinW-1:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [5:0]  tens10;
    prod   = v * 8'd205;
    tens   = 4'(prod >> 11);
    tens10 = 6'(tens) * 6'd10;
    return {tens, 4'(v - tens10)};
  endfunction

  function automatic logic [CharWidth-1:0] code_to_ascii(input logic [CodeWidth-1:0] code);
    logic [CharWidth-1:0] c;
    case (code)
      CODE_SPACE: c = ASCII_SPACE;
      CODE_COLON: c = ASCII_COLON;
      default:    c = ASCII_ZERO + {2'b00, code};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/s2t_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2t_ctrl: sequencer for seconds_to_dhms_text
// Steps the datapath through the three split phases, the days digit
// extraction, the text assembly and the character output.
// ----------------------------------------------------------------------------
module s2t_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  out_valid,
  output logic                  out_last_char,
  output s2t_pkg::ctl_cmd_t     cmd,
  input  wire s2t_pkg::ctl_sts_t sts
);
  import s2t_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPLIT = 3'd1;
  localparam logic [2:0] ST_DIGIT = 3'd2;
  localparam logic [2:0] ST_PACK  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.phase = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
          phase_nxt = PH_DAYS;
          cnt_nxt   = 4'd1;
        end
      end
      ST_SPLIT: begin
        // Quotient first, then the reduced remainder
        if (cnt_r != 4'd0) begin
          cmd.quot = 1'b1;
          cnt_nxt  = cnt_r - 4'd1;
        end else begin
          cmd.reduce = 1'b1;
          if (phase_r == PH_MINS) begin
            state_nxt = ST_DIGIT;
            cnt_nxt   = 4'(DaysDigits - 1);
          end else begin
            phase_nxt = phase_r + 2'd1;
            cnt_nxt   = 4'd1;
          end
        end
      end
      ST_DIGIT: begin
        cmd.digit = 1'b1;
        if (cnt_r == 4'd0) begin
          state_nxt = ST_PACK;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      ST_PACK: begin
        cmd.pack  = 1'b1;
        cnt_nxt   = sts.len - 4'd1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        if (cnt_r == 4'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_DAYS;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_EMIT);
  assign out_last_char = (state_r == ST_EMIT) && (cnt_r == 4'd0);

endmodule
`default_nettype wire

FILE: rtl/s2t_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s2t_dp: datapath for seconds_to_dhms_text
// Reciprocal-multiply split of the count into fields, decimal digits of the
// days, field registers and the character shift register.
// ----------------------------------------------------------------------------
module s2t_dp (
  input  wire logic                             clk,
  input  wire logic [s2t_pkg::SecWidth-1:0]     in_total_seconds,
  input  wire s2t_pkg::ctl_cmd_t                cmd,
  output s2t_pkg::ctl_sts_t                     sts,
  output logic [s2t_pkg::CharWidth-1:0]         out_text_char
);
  import s2t_pkg::*;

  logic [SecWidth-1:0]  rem_r, rem_nxt;
  logic [DaysBinW-1:0]  quo_r, quo_nxt;
  logic [DaysBinW-1:0]  dd_r, dd_nxt;
  logic [DaysBcdW-1:0]  days_r, days_nxt;
  logic [FieldBinW-1:0] hours_r, hours_nxt;
  logic [FieldBinW-1:0] mins_r, mins_nxt;
  logic [StrWidth-1:0]  str_r, str_nxt;
  logic [StrWidth-1:0]  full_str;
  logic [1:0]           skip;
  logic [50:0]          day_prod;
  logic [26:0]          hour_prod;
  logic [20:0]          min_prod;
  logic [DaysBinW-1:0]  quo_phase;
  logic [SecWidth-1:0]  sub_amt;
  logic [31:0]          dec_prod;
  logic [DaysBinW-1:0]  dec_quo;
  logic [DaysBinW-1:0]  dec_quo10;
  logic [3:0]           dec_digit;

  // Quotient of the remainder by each divisor
  assign day_prod  = rem_r[31:7] * RECIP_DAY;
  assign hour_prod = rem_r[16:4] * RECIP_HOUR;
  assign min_prod  = rem_r[11:2] * RECIP_MIN;

  always_comb begin
    case (cmd.phase)
      PH_DAYS:  quo_phase = DaysBinW'(day_prod >> 35);
      PH_HOURS: quo_phase = DaysBinW'(hour_prod >> 21);
      PH_MINS:  quo_phase = DaysBinW'(min_prod >> 14);
      default:  quo_phase = '0;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      PH_DAYS:  sub_amt = SecWidth'(quo_r) * SECS_PER_DAY;
      PH_HOURS: sub_amt = SecWidth'(quo_r) * SECS_PER_HOUR;
      PH_MINS:  sub_amt = SecWidth'(quo_r) * SECS_PER_MIN;
      default:  sub_amt = '0;
    endcase
  end

  // Lowest decimal digit of the remaining days
  assign dec_prod  = dd_r * RECIP_TEN;
  assign dec_quo   = DaysBinW'(dec_prod >> 19);
  assign dec_quo10 = dec_quo * 16'd10;
  assign dec_digit = 4'(dd_r - dec_quo10);

  // Drop leading zero digits of days, keeping at least two
  always_comb begin
    if (days_r[19:16] != 4'd0) begin
      skip = 2'd0;
    end else if (days_r[15:12] != 4'd0) begin
      skip = 2'd1;
    end else if (days_r[11:8] != 4'd0) begin
      skip = 2'd2;
    end else begin
      skip = 2'd3;
    end
  end

  assign sts.len  = 4'(MaxChars) - {2'b00, skip};
  assign full_str = {days_r, CODE_SPACE, bcd2(hours_r), CODE_COLON, bcd2(mins_r),
                     CODE_COLON, bcd2(rem_r[FieldBinW-1:0])};

  always_comb begin
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dd_nxt    = dd_r;
    days_nxt  = days_r;
    hours_nxt = hours_r;
    mins_nxt  = mins_r;
    str_nxt   = str_r;
    if (cmd.load) begin
      rem_nxt = in_total_seconds;
    end
    if (cmd.quot) begin
      quo_nxt = quo_phase;
    end
    if (cmd.reduce) begin
      // Keep the remainder, store the field; seconds are what is left
      rem_nxt = rem_r - sub_amt;
      case (cmd.phase)
        PH_DAYS:  dd_nxt    = quo_r;
        PH_HOURS: hours_nxt = FieldBinW'(quo_r);
        PH_MINS:  mins_nxt  = FieldBinW'(quo_r);
        default:  dd_nxt    = dd_r;
      endcase
    end
    if (cmd.digit) begin
      // Lowest digit enters at the top and moves down one slot per step
      dd_nxt   = dec_quo;
      days_nxt = {dec_digit, days_r[DaysBcdW-1:CodeWidth]};
    end
    if (cmd.pack) begin
      case (skip)
        2'd0:    str_nxt = full_str;
        2'd1:    str_nxt = full_str << CodeWidth;
        2'd2:    str_nxt = full_str << (2 * CodeWidth);
        default: str_nxt = full_str << (3 * CodeWidth);
      endcase
    end
    if (cmd.shift) begin
      str_nxt = str_r << CodeWidth;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dd_r    <= dd_nxt;
    days_r  <= days_nxt;
    hours_r <= hours_nxt;
    mins_r  <= mins_nxt;
    str_r   <= str_nxt;
  end

  assign out_text_char = code_to_ascii(str_r[StrWidth-1 -: CodeWidth]);

endmodule
`default_nettype wire

FILE: rtl/seconds_to_dhms_text.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_dhms_text: seconds count to "D HH:MM:SS" ASCII text
// Splits a 32-bit seconds count into days, hours, minutes and seconds and
// sends the text out one character per cycle.
// ----------------------------------------------------------------------------
// A transaction starts at a clock edge with start high and busy low. Busy
// then stays high until the last character is out: the split into fields
// (a reciprocal-multiply quotient and a remainder update for each of days,
// hours and minutes), then the decimal digits of the days, then the text
// assembly, then 11 to 14 characters leave one per cycle, and busy drops
// before the next start is taken. Each character is on out_text_char for
// exactly one cycle with out_valid high; the receiver cannot stall, so it
// must take every one. out_last_char marks the final character. Days print
// with at least two digits and up to five; no terminator is sent.
// ----------------------------------------------------------------------------
module seconds_to_dhms_text (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [s2t_pkg::SecWidth-1:0] in_total_seconds,
  output logic                              out_valid,
  output logic [s2t_pkg::CharWidth-1:0]     out_text_char,
  output logic                              out_last_char
);
  import s2t_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequence the phases and time the character strobes
  s2t_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_last_char (out_last_char),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Split into fields, extract digits, hold the text
  s2t_dp u_dp (
    .clk              (clk),
    .in_total_seconds (in_total_seconds),
    .cmd              (cmd),
    .sts              (sts),
    .out_text_char    (out_text_char)
  );

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for seconds_to_dhms_text
// Sends second counts through the start/busy handshake and checks each
// character strobe against a predicted "D HH:MM:SS" text, in order.
// ----------------------------------------------------------------------------
module tb;
  import s2t_pkg::*;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MaxDays     = 49710;
  localparam int          MaxGap      = 11;
  localparam int          DrainCycles = 64;

  // One predicted character of the formatted text
  typedef struct {
    logic [CharWidth-1:0] text_char;
    logic                 last_char;
  } text_char_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic [SecWidth-1:0]  in_total_seconds = '0;
  logic                 busy;
  logic                 out_valid;
  logic [CharWidth-1:0] out_text_char;
  logic                 out_last_char;

  // Characters still owed by the block, oldest first
  text_char_t  expected_chars[$];
  int unsigned fail_count = 0;
  // When set, the sender raises start again at once, with no idle cycles
  bit          back_to_back = 1'b0;

  seconds_to_dhms_text u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_total_seconds (in_total_seconds),
    .out_valid        (out_valid),
    .out_text_char    (out_text_char),
    .out_last_char    (out_last_char)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Text predictor
  // --------------------------------------------------------------------------
  function automatic void push_text_char(input logic [CharWidth-1:0] ch);
    text_char_t c;
    c.text_char = ch;
    c.last_char = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // Decimal, most significant digit first, never fewer than two digits
  function automatic void push_padded_number(input int unsigned value);
    int unsigned digit_buf[10];
    int unsigned v;
    int          n;
    v = value;
    n = 0;
    do begin
      digit_buf[n] = v % 10;
      v = v / 10;
      n++;
    end while (v != 0);
    if (n < 2) begin
      digit_buf[1] = 0;
      n = 2;
    end
    for (int k = n - 1; k >= 0; k--) begin
      push_text_char(ASCII_ZERO + CharWidth'(digit_buf[k]));
    end
  endfunction

  function automatic void predict_dhms_text(input logic [SecWidth-1:0] total);
    int unsigned rest;
    int unsigned days;
    int unsigned hours;
    int unsigned minutes;
    rest    = total;
    days    = rest / SecsPerDay;
    rest    = rest % SecsPerDay;
    hours   = rest / SecsPerHour;
    rest    = rest % SecsPerHour;
    minutes = rest / SecsPerMin;
    rest    = rest % SecsPerMin;
    push_padded_number(days);
    push_text_char(ASCII_SPACE);
    push_padded_number(hours);
    push_text_char(ASCII_COLON);
    push_padded_number(minutes);
    push_text_char(ASCII_COLON);
    push_padded_number(rest);
    // Flag the final character of this transaction
    expected_chars[expected_chars.size() - 1].last_char = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one transaction per call
  // --------------------------------------------------------------------------
  // Wait a random gap, counted either from the previous accept or from the
  // moment the block goes idle, then hold start until the block takes it.
  // Start is left high on return so a zero gap runs back to back.
  task automatic send_seconds(input logic [SecWidth-1:0] value);
    int gap;
    bit from_idle;
    gap       = back_to_back ? 0 : $urandom_range(0, MaxGap);
    from_idle = $urandom_range(0, 1);
    if (gap > 0) begin
      start <= 1'b0;
      if (from_idle) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_total_seconds <= value;
    // Advance until an edge samples start high with busy low
    do @(posedge clk); while (busy);
    predict_dhms_text(value);
  endtask

  // --------------------------------------------------------------------------
  // Checker: every strobe must match the oldest predicted character
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        $error("out_text_char: expected none, got %0d", out_text_char);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_text_char !== want.text_char) begin
          $error("out_text_char: expected %0d, got %0d", want.text_char, out_text_char);
          fail_count++;
        end
        if (out_last_char !== want.last_char) begin
          $error("out_last_char: expected %0d, got %0d", want.last_char, out_last_char);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Input extremes, field rollovers and alternating bit patterns
  task automatic test_field_extremes();
    send_seconds(32'd0);
    send_seconds(32'hFFFF_FFFF);
    send_seconds(32'd1);
    send_seconds(32'd59);
    send_seconds(32'd60);
    send_seconds(32'd3599);
    send_seconds(32'd3600);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    send_seconds(32'h8000_0000);
    send_seconds(32'h5555_5555);
    send_seconds(32'hAAAA_AAAA);
  endtask

  // Day counts on each side of every digit-count step, up to five digits
  task automatic test_day_digit_counts();
    send_seconds(32'd863999);      // 9 days, last padded value
    send_seconds(32'd864000);      // 10 days
    send_seconds(32'd8639999);     // 99 days
    send_seconds(32'd8640000);     // 100 days
    send_seconds(32'd86399999);    // 999 days
    send_seconds(32'd86400000);    // 1000 days
    send_seconds(32'd863999999);   // 9999 days
    send_seconds(32'd864000000);   // 10000 days
    send_seconds(32'd4294943999);  // largest count with every field at its max
  endtask

  // Random counts: full range, short spans, composed fields, near 10^n days
  task automatic test_random_counts();
    logic [SecWidth-1:0] value;
    int unsigned         days;
    int unsigned         hours;
    int unsigned         minutes;
    int unsigned         secs;
    int unsigned         pow10;
    for (int i = 0; i < 89; i++) begin
      // Switch the idle pattern now and then to get unbroken stretches
      if (i % 16 == 0) begin
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 3))
        0: value = $urandom;
        1: value = $urandom_range(0, 10 * SecsPerDay - 1);
        2: begin
          days    = $urandom_range(0, 2) == 0 ? MaxDays - 1 : $urandom_range(0, MaxDays - 1);
          hours   = $urandom_range(0, 2) == 0 ? 23 : $urandom_range(0, 23);
          minutes = $urandom_range(0, 2) == 0 ? 59 : $urandom_range(0, 59);
          secs    = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 59);
          value   = days * SecsPerDay + hours * SecsPerHour + minutes * SecsPerMin + secs;
        end
        default: begin
          // Near a power-of-ten day boundary
          pow10 = 1;
          repeat ($urandom_range(1, 4)) pow10 = pow10 * 10;
          value = pow10 * SecsPerDay - 2 + $urandom_range(0, 3);
        end
      endcase
      send_seconds(value);
    end
    back_to_back = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_day_digit_counts();
    test_random_counts();
    start <= 1'b0;

    // Drain the last text, then watch for stray strobes
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/s2t_pkg.sv
rtl/s2t_ctrl.sv
rtl/s2t_dp.sv
rtl/seconds_to_dhms_text.sv
sim/tb.sv
